[sv/vn_pkg.sv]
// vn_pkg: shared widths, word structs and lane types for the vector normalize block
// no dependencies; imported by every module of the block
package vn_pkg;

    // component and output formats
    localparam int CW     = 32;          // component width, Q16.16
    localparam int FB     = 30;          // output fraction bits
    localparam int UW     = FB + 2;      // output unit width, Q1.FB
    localparam int SQ_W   = 2 * CW;      // one square
    localparam int SUM_W  = 2 * CW + 2;  // sum of three squares
    localparam int ROOT_W = SUM_W / 2;   // root bits from the radicand
    localparam int REM_W  = ROOT_W + 2;  // root remainder width
    localparam int DIV_STEPS = FB + 1;   // quotient bits per lane
    localparam int LANES  = 3;

    // input word
    typedef struct packed {
        logic signed [CW-1:0] vec_x;
        logic signed [CW-1:0] vec_y;
        logic signed [CW-1:0] vec_z;
    } vec_word_t;

    // result word
    typedef struct packed {
        logic signed [UW-1:0] unit_x;
        logic signed [UW-1:0] unit_y;
        logic signed [UW-1:0] unit_z;
        logic [CW-1:0]        length;
        logic                 was_zero;
    } out_word_t;

    // magnitudes and signs carried alongside the root
    typedef struct packed {
        logic [LANES-1:0][CW-1:0] mag;
        logic [LANES-1:0]         neg;
    } mag_tag_t;

    // what one divider lane hands to the merge stage
    typedef struct packed {
        logic [FB:0]   quot;
        logic          neg;
        logic [CW-1:0] den;
    } lane_res_t;

endpackage

[sv/vn_sqrt_pipe.sv]
// vn_sqrt_pipe: pipelined integer square root, one root bit per stage
// depends on vn_pkg
module vn_sqrt_pipe (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [vn_pkg::SUM_W-1:0] in_sum,
    input  vn_pkg::mag_tag_t       in_tag,
    output logic                   out_valid,
    output logic [vn_pkg::CW-1:0]  out_root,
    output vn_pkg::mag_tag_t       out_tag
);
    import vn_pkg::*;

    logic [SUM_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    mag_tag_t          tag_reg  [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [SUM_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        mag_tag_t          tag_in;
        logic              vld_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        // stage inputs
        if (s == 0) begin : g_first
            assign rad_in  = in_sum;
            assign rem_in  = '0;
            assign root_in = '0;
            assign tag_in  = in_tag;
            assign vld_in  = in_valid;
        end
        else begin : g_next
            assign rad_in  = rad_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign tag_in  = tag_reg[s-1];
            assign vld_in  = vld_reg[s-1];
        end

        // bring down two radicand bits and try the next root bit
        assign rem_sh = {rem_in[REM_W-3:0], rad_in[SUM_W-1:SUM_W-2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s]  <= rad_in << 2;
                rem_reg[s]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[s] <= {root_in[ROOT_W-2:0], ge};
                tag_reg[s]  <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1][CW-1:0];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

[sv/vn_div_lane.sv]
// vn_div_lane: pipelined restoring divider, |c| * 2^FB / norm, one quotient bit per stage
// depends on vn_pkg
module vn_div_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [vn_pkg::CW-1:0] in_mag,
    input  logic                  in_neg,
    input  logic [vn_pkg::CW-1:0] in_den,
    output logic                  out_valid,
    output vn_pkg::lane_res_t     out_res
);
    import vn_pkg::*;

    logic [CW:0]   rem_reg [DIV_STEPS];
    logic [FB:0]   q_reg   [DIV_STEPS];
    logic [CW-1:0] den_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] neg_reg;
    logic [DIV_STEPS-1:0] vld_reg;

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
        logic [CW:0]   rem_in;
        logic          feed;
        logic [FB:0]   q_in;
        logic [CW-1:0] den_in;
        logic          neg_in;
        logic          vld_in;
        logic [CW:0]   rem_sh;
        logic          ge;

        // upper numerator bits are |c| >> 1, already below the norm
        if (s == 0) begin : g_first
            assign rem_in = {2'b00, in_mag[CW-1:1]};
            assign feed   = in_mag[0];
            assign q_in   = '0;
            assign den_in = in_den;
            assign neg_in = in_neg;
            assign vld_in = in_valid;
        end
        else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign feed   = 1'b0;
            assign q_in   = q_reg[s-1];
            assign den_in = den_reg[s-1];
            assign neg_in = neg_reg[s-1];
            assign vld_in = vld_reg[s-1];
        end

        // shift in one numerator bit and subtract when it fits
        assign rem_sh = {rem_in[CW-1:0], feed};
        assign ge     = (rem_sh >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? (rem_sh - {1'b0, den_in}) : rem_sh;
                q_reg[s]   <= {q_in[FB-1:0], ge};
                den_reg[s] <= den_in;
                neg_reg[s] <= neg_in;
            end
        end
    end

    assign out_valid    = vld_reg[DIV_STEPS-1];
    assign out_res.quot = q_reg[DIV_STEPS-1];
    assign out_res.neg  = neg_reg[DIV_STEPS-1];
    assign out_res.den  = den_reg[DIV_STEPS-1];

endmodule

[sv/vn_merge.sv]
// vn_merge: combines the three lanes, applies signs and the zero guard,
// holds the result word in an output register with a skid stage; depends on vn_pkg
module vn_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [vn_pkg::CW-1:0]              min_norm,
    input  logic                               lane_valid,
    input  vn_pkg::lane_res_t [vn_pkg::LANES-1:0] lane_res,
    output logic                               en,
    output logic                               out_valid,
    input  logic                               out_ready,
    output vn_pkg::out_word_t                  out_word
);
    import vn_pkg::*;

    logic              zero;
    logic [LANES-1:0][UW-1:0] unit;
    out_word_t         res;
    logic              take;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    out_word_t         out_reg;
    out_word_t         skid_reg;
    logic              load_out;

    // zero guard and sign restore
    assign zero = (lane_res[0].den <= min_norm);

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (zero)
                unit[k] = '0;
            else if (lane_res[k].neg)
                unit[k] = UW'(0) - {1'b0, lane_res[k].quot};
            else
                unit[k] = {1'b0, lane_res[k].quot};
        end
    end

    assign res.unit_x   = unit[0];
    assign res.unit_y   = unit[1];
    assign res.unit_z   = unit[2];
    assign res.length   = lane_res[0].den;
    assign res.was_zero = zero;

    // pipeline moves while the skid stage is empty
    assign en       = !skid_valid_reg;
    assign take     = lane_valid && en;
    assign load_out = out_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg  <= skid_valid_reg || take;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (take)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

[sv/vector3_normalize_top.sv]
// vector3_normalize_top: 3D vector normalization, squares, pipelined root,
// three divider lanes and a merge stage; depends on vn_pkg and all vn_* modules
//
//  channel   signals                       word
//  -------   ---------------------------   ---------------------------------
//  input     in_valid / in_ready           in_word  (vec_x, vec_y, vec_z)
//  output    out_valid / out_ready         out_word (unit_x/y/z, length, was_zero)
//  config    cfg_we / cfg_wdata            min_norm, written on each clock edge with cfg_we high
//
// one word accepted per cycle while in_ready is high; the path runs through magnitude, square and sum
// stages, 33 root stages (one bit each), 31 divider stages per lane and one output register.
// reset clears all valid bits and sets min_norm to zero.
// a stalled output parks one word in the skid stage; the whole pipeline then holds
// until that word drains, and in_ready drops for that time.
module vector3_normalize_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vn_pkg::vec_word_t     in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vn_pkg::out_word_t     out_word,
    input  logic                  cfg_we,
    input  logic [vn_pkg::CW-1:0] cfg_wdata
);
    import vn_pkg::*;

    logic              en;
    logic [CW-1:0]     min_norm_reg;
    logic [LANES-1:0][CW-1:0] comp;
    logic              v0_reg;
    logic              v1_reg;
    logic              v2_reg;
    mag_tag_t          tag0_reg;
    mag_tag_t          tag1_reg;
    mag_tag_t          tag2_reg;
    logic [LANES-1:0][SQ_W-1:0] sq_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              root_valid;
    logic [CW-1:0]     norm;
    mag_tag_t          root_tag;
    logic [LANES-1:0]  lane_valid;
    lane_res_t [LANES-1:0] lane_res;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_norm_reg <= '0;
        else if (cfg_we)
            min_norm_reg <= cfg_wdata;
    end

    assign in_ready = en;
    assign comp[0]  = in_word.vec_x;
    assign comp[1]  = in_word.vec_y;
    assign comp[2]  = in_word.vec_z;

    // valid chain of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // magnitude, square and sum stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                tag0_reg.neg[k] <= comp[k][CW-1];
                tag0_reg.mag[k] <= comp[k][CW-1] ? (CW'(0) - comp[k]) : comp[k];
                sq_reg[k]       <= tag0_reg.mag[k] * tag0_reg.mag[k];
            end
            tag1_reg <= tag0_reg;
            sum_reg  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            tag2_reg <= tag1_reg;
        end
    end

    vn_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_sum    (sum_reg),
        .in_tag    (tag2_reg),
        .out_valid (root_valid),
        .out_root  (norm),
        .out_tag   (root_tag)
    );

    // one divider lane per component
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        vn_div_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (root_valid),
            .in_mag    (root_tag.mag[k]),
            .in_neg    (root_tag.neg[k]),
            .in_den    (norm),
            .out_valid (lane_valid[k]),
            .out_res   (lane_res[k])
        );
    end

    vn_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .min_norm   (min_norm_reg),
        .lane_valid (lane_valid[0]),
        .lane_res   (lane_res),
        .en         (en),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word)
    );

    // checks
    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        lane_valid[0] == lane_valid[1] && lane_valid[1] == lane_valid[2])
        else $error("divider lanes out of step");

    a_hold_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("pipeline held with no word at the output");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.was_zero |->
            out_word.unit_x == '0 && out_word.unit_y == '0 && out_word.unit_z == '0)
        else $error("zero guard left a unit component set");

    a_front_moves: assert property (@(posedge clk) disable iff (!rst_n)
        en && v0_reg |=> v1_reg)
        else $error("front stage lost a word");

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for vector3_normalize_top
// depends on vn_pkg and the vector3_normalize_top rtl; no files or arguments needed

// expected-result store for normalized vectors
class norm_scoreboard;
    vn_pkg::out_word_t pending[$];
    logic [31:0] min_norm;
    int mismatches;

    function new();
        min_norm = '0;
        mismatches = 0;
    endfunction

    // integer square root of a 66-bit radicand, one bit at a time
    function automatic logic [32:0] isqrt(logic [65:0] n);
        logic [32:0] r;
        logic [32:0] cand;
        r = '0;
        for (int i = 32; i >= 0; i--) begin
            cand = r | (33'd1 << i);
            if ({33'd0, cand} * {33'd0, cand} <= n) r = cand;
        end
        return r;
    endfunction

    // predict the result word for one vector
    function automatic vn_pkg::out_word_t predict(vn_pkg::vec_word_t v);
        vn_pkg::out_word_t o;
        logic [31:0] mag[3];
        logic neg[3];
        logic signed [31:0] comp[3];
        logic [65:0] sumsq;
        logic [32:0] root;
        logic [63:0] q;
        comp[0] = v.vec_x;
        comp[1] = v.vec_y;
        comp[2] = v.vec_z;
        sumsq = '0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = comp[k][31];
            mag[k] = neg[k] ? -comp[k] : comp[k];
            sumsq += {34'd0, mag[k]} * {34'd0, mag[k]};
        end
        root = isqrt(sumsq);
        o = '0;
        o.length = root[31:0];
        if (root <= {1'b0, min_norm}) begin
            o.was_zero = 1'b1;
        end
        else begin
            for (int k = 0; k < 3; k++) begin
                q = ({32'd0, mag[k]} << 30) / {31'd0, root};
                if (neg[k]) q = -q;
                if (k == 0) o.unit_x = q[31:0];
                if (k == 1) o.unit_y = q[31:0];
                if (k == 2) o.unit_z = q[31:0];
            end
        end
        return o;
    endfunction

    function void note_vector(vn_pkg::vec_word_t v);
        pending.push_back(predict(v));
    endfunction

    function void check_result(vn_pkg::out_word_t got);
        vn_pkg::out_word_t exp_w;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
            return;
        end
        exp_w = pending.pop_front();
        if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp x=%h y=%h z=%h len=%h zero=%b",
                          " got x=%h y=%h z=%h len=%h zero=%b"},
                    exp_w.unit_x, exp_w.unit_y, exp_w.unit_z, exp_w.length, exp_w.was_zero,
                    got.unit_x, got.unit_y, got.unit_z, got.length, got.was_zero);
        end
    endfunction
endclass

module tb_top;
    import vn_pkg::*;

    localparam int LATENCY = 68;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    vec_word_t in_word;
    logic out_valid;
    logic out_ready;
    out_word_t out_word;
    logic cfg_we;
    logic [CW-1:0] cfg_wdata;

    norm_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int quiet_cycles;

    vector3_normalize_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) sb.check_result(out_word);
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // offer one vector and wait for its acceptance; valid stays up for the next word
    task automatic send_vector(vec_word_t v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_vector(v);
    endtask

    // wait for the pipeline to drain, then write min_norm
    task automatic write_min_norm(logic [31:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.min_norm = value;
    endtask

    // random component, biased toward small and extreme values
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom_range(255) - 128;
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return 32'h7fff_ffff - $urandom_range(3);
            3: return $urandom_range(32'h0003_0000) - 32'h0001_8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_word_t rand_vector();
        vec_word_t v;
        v.vec_x = rand_comp();
        v.vec_y = rand_comp();
        v.vec_z = rand_comp();
        if ($urandom_range(9) == 0) v.vec_y = 0;
        if ($urandom_range(19) == 0) v = '0;
        return v;
    endfunction

    task automatic send_directed();
        logic [31:0] vals[8];
        vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'h0001_0000, 32'hffff_0000, 32'h0000_8000};
        send_vector('0);
        for (int i = 0; i < 8; i++) send_vector('{vals[i], 32'h0, 32'h0});
        for (int i = 0; i < 8; i++) send_vector('{vals[i], vals[(i + 3) % 8], vals[(i + 5) % 8]});
        send_vector('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_vector('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_vector('{32'h0, 32'h0, 32'h0000_0003});
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_vector(rand_vector());
    endtask

    initial
    begin
        int drain;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed vectors at reset threshold
        send_directed();
        run_phase(100, 0, 0);

        // small threshold
        write_min_norm(32'h0000_0002);
        send_directed();
        run_phase(100, 57, 0);

        // long receiver hold-off while the sender keeps pushing
        hold_off_cycles = 300;
        run_phase(100, 0, 57);

        // mid threshold, one unit
        write_min_norm(32'h0001_0000);
        run_phase(100, 10, 10);

        // top threshold: every vector counts as zero
        write_min_norm(32'hffff_ffff);
        send_directed();
        run_phase(40, 0, 0);

        // back to zero
        write_min_norm(32'h0);
        run_phase(60, 10, 10);

        // drain
        in_valid <= 1'b0;
        drain = 0;
        while (sb.pending.size() != 0 && drain < WATCHDOG_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end
        else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
